// ===== rtl/fbpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and constants of the fixed block pool allocator: payload
// structs, command and status codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    // Command codes of an input item.
    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_REINIT = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    // Status codes of a result item.
    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_BAD_ADDR     = 3'd1,
        ST_ALREADY_FREE = 3'd2,
        ST_EMPTY        = 3'd3,
        ST_FULL         = 3'd4
    } t_status;

    // Configuration register indexes.
    localparam logic [1:0] CFG_POOL_BASE     = 2'd0;
    localparam logic [1:0] CFG_BLOCK_BYTES   = 2'd1;
    localparam logic [1:0] CFG_BLOCKS_IN_USE = 2'd2;

    localparam logic [31:0] RST_POOL_BASE     = 32'd0;
    localparam logic [15:0] RST_BLOCK_BYTES   = 16'd64;
    localparam logic [8:0]  RST_BLOCKS_IN_USE = 9'd256;

    // Scale of the percentage outputs.
    localparam logic [15:0] PCT_SCALE = 16'd100;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] block_address;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] granted_address;
        logic [8:0]  free_blocks;
        logic [8:0]  used_blocks;
        logic [8:0]  peak_used;
        logic [31:0] alloc_total;
        logic [31:0] free_total;
        logic [6:0]  free_percent;
        logic [6:0]  usage_percent;
    } t_out;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLR_MARK,
        OP_CAPTURE,
        OP_POP,
        OP_GRANT_MUL,
        OP_GRANT_ADD,
        OP_RANGE,
        OP_DIV_OFF,
        OP_MARK_RD,
        OP_PUSH,
        OP_DIV_FPCT,
        OP_SET_FPCT,
        OP_REINIT,
        OP_FILL,
        OP_DIV_UPCT,
        OP_SET_UPCT
    } t_op;

    typedef struct packed {
        t_op     op;
        logic    set_status;
        t_status status;
        logic    load_out;
    } t_ctrl;

    typedef struct packed {
        t_cmd cmd;
        logic level_zero;
        logic range_ok;
        logic rem_zero;
        logic mark_set;
        logic full;
        logic div_busy;
        logic sweep_last;
    } t_dp_stat;

    // Controller states.
    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_DISPATCH,
        S_POP,
        S_GMUL,
        S_GADD,
        S_RANGE,
        S_DIV_OFF,
        S_WAIT_OFF,
        S_MARK_RD,
        S_CHECK,
        S_PUSH,
        S_DIV_FPCT,
        S_WAIT_FPCT,
        S_REINIT,
        S_FILL,
        S_DIV_UPCT,
        S_WAIT_UPCT,
        S_DONE
    } t_state;

endpackage

// ===== rtl/fbpa_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_div
// Restoring divider, one quotient bit per cycle. A full divide takes 32
// steps; a short divide of a 16-bit dividend takes 16 steps.
// ----------------------------------------------------------------------------
module fbpa_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_short,
    input  logic [31:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_busy,
    output logic [31:0] o_quot,
    output logic [15:0] o_rem
);
    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [31:0] r_q;
    logic [15:0] r_rem;
    logic [15:0] r_dvs;
    logic [16:0] w_sh;
    logic [16:0] w_diff;
    logic        w_ge;

    // One restoring step.
    assign w_sh   = {r_rem, r_q[31]};
    assign w_ge   = w_sh >= {1'b0, r_dvs};
    assign w_diff = w_sh - {1'b0, r_dvs};

    // Control of the iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 5'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_short ? 5'd15 : 5'd31;
        end else if (r_busy) begin
            if (r_cnt == 5'd0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 5'd1;
            end
        end
    end

    // Quotient and remainder registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_short ? {i_dividend[15:0], 16'd0} : i_dividend;
            r_rem <= 16'd0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[30:0], w_ge};
            r_rem <= w_ge ? w_diff[15:0] : w_sh[15:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/fbpa_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_datapath
// Configuration registers, free stack and free marks, statistics, address
// arithmetic and the shared divider, driven by controller operations.
// ----------------------------------------------------------------------------
module fbpa_datapath #(
    parameter int MAX_BLOCKS = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [31:0]      i_cfg_data,
    input  fbpa_pkg::t_in    i_in,
    input  fbpa_pkg::t_ctrl  i_ctrl,
    output fbpa_pkg::t_dp_stat o_stat,
    output fbpa_pkg::t_out   o_out
);
    import fbpa_pkg::*;

    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int SW = $clog2(MAX_BLOCKS + 1);
    localparam int CW = (SW > 9) ? SW : 9;

    // Configuration.
    logic [31:0] r_base;
    logic [15:0] r_bb;
    logic [8:0]  r_biu;

    // Pool state and statistics.
    logic [8:0]  r_level;
    logic [8:0]  r_peak;
    logic [31:0] r_alloc;
    logic [31:0] r_free;
    logic [6:0]  r_fpct;
    logic [6:0]  r_upct;

    // Per-item working registers.
    t_cmd        r_cmd;
    logic [31:0] r_addr;
    logic [24:0] r_span;
    logic        r_range_ok;
    logic [31:0] r_off;
    logic [IW-1:0] r_idx;
    logic [27:0] r_prod;
    logic [2:0]  r_status;
    logic [31:0] r_grant;
    logic [SW-1:0] r_sweep;
    t_out        r_out;

    // Memories.
    logic [IW-1:0] r_stack [MAX_BLOCKS];
    logic          r_mark  [MAX_BLOCKS];
    logic [IW-1:0] r_stk_q;
    logic          r_mark_q;

    logic [8:0]  w_n;
    logic [8:0]  w_used;
    logic [15:0] w_pct_num;
    logic        w_full;
    logic        w_stk_we;
    logic [IW-1:0] w_stk_waddr;
    logic [IW-1:0] w_stk_wdata;
    logic        w_mark_we;
    logic [IW-1:0] w_mark_waddr;
    logic        w_mark_wdata;
    logic        w_div_start;
    logic        w_div_short;
    logic [31:0] w_div_dividend;
    logic [15:0] w_div_divisor;
    logic        w_div_busy;
    logic [31:0] w_quot;
    logic [15:0] w_rem;

    // Effective block count and derived levels.
    always_comb begin
        if (32'(r_biu) > 32'(MAX_BLOCKS)) begin
            w_n = 9'(MAX_BLOCKS);
        end else begin
            w_n = r_biu;
        end
        w_used    = (r_level >= w_n) ? 9'd0 : (w_n - r_level);
        w_full    = r_level >= w_n;
        w_pct_num = (i_ctrl.op == OP_DIV_FPCT) ? 16'(r_level) * PCT_SCALE
                                               : 16'(w_used) * PCT_SCALE;
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= RST_POOL_BASE;
            r_bb   <= RST_BLOCK_BYTES;
            r_biu  <= RST_BLOCKS_IN_USE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POOL_BASE:     r_base <= i_cfg_data;
                CFG_BLOCK_BYTES:   r_bb   <= i_cfg_data[15:0];
                CFG_BLOCKS_IN_USE: r_biu  <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Pool state and statistics.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= 9'd0;
            r_peak  <= 9'd0;
            r_alloc <= 32'd0;
            r_free  <= 32'd0;
            r_fpct  <= 7'd0;
            r_sweep <= '0;
        end else begin
            case (i_ctrl.op)
                OP_CLR_MARK, OP_FILL: begin
                    r_sweep <= r_sweep + SW'(1);
                end
                OP_CAPTURE: begin
                    r_sweep <= '0;
                end
                OP_POP: begin
                    r_level <= r_level - 9'd1;
                end
                OP_GRANT_MUL: begin
                    r_alloc <= r_alloc + 32'd1;
                    if (w_used > r_peak) begin
                        r_peak <= w_used;
                    end
                end
                OP_PUSH: begin
                    r_level <= r_level + 9'd1;
                    r_free  <= r_free + 32'd1;
                end
                OP_SET_FPCT: begin
                    r_fpct <= w_quot[6:0];
                end
                OP_REINIT: begin
                    r_level <= w_n;
                    r_peak  <= 9'd0;
                    r_alloc <= 32'd0;
                    r_free  <= 32'd0;
                    r_fpct  <= 7'd0;
                end
                default: ;
            endcase
        end
    end

    // Per-item working registers.
    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            OP_CAPTURE: begin
                r_cmd    <= t_cmd'(i_in.command);
                r_addr   <= i_in.block_address;
                r_span   <= 25'(w_n) * 25'(r_bb);
                r_grant  <= 32'd0;
            end
            OP_GRANT_MUL: begin
                r_prod <= 28'(r_stk_q) * 28'(r_bb);
            end
            OP_GRANT_ADD: begin
                r_grant <= r_base + 32'(r_prod);
            end
            OP_RANGE: begin
                r_range_ok <= (r_addr >= r_base) && ((r_addr - r_base) < 32'(r_span));
                r_off      <= r_addr - r_base;
            end
            OP_MARK_RD: begin
                r_idx <= IW'(w_quot);
            end
            OP_SET_UPCT: begin
                r_upct <= (w_n == 9'd0) ? 7'd0 : w_quot[6:0];
            end
            default: ;
        endcase
        if (i_ctrl.set_status) begin
            r_status <= i_ctrl.status;
        end else if (i_ctrl.op == OP_CAPTURE) begin
            r_status <= ST_OK;
        end
    end

    // Write ports of the stack and the marks.
    always_comb begin
        w_stk_we     = 1'b0;
        w_stk_waddr  = IW'(r_level);
        w_stk_wdata  = r_idx;
        w_mark_we    = 1'b0;
        w_mark_waddr = r_idx;
        w_mark_wdata = 1'b0;
        case (i_ctrl.op)
            OP_CLR_MARK: begin
                w_mark_we    = 1'b1;
                w_mark_waddr = IW'(r_sweep);
            end
            OP_GRANT_MUL: begin
                w_mark_we    = 1'b1;
                w_mark_waddr = r_stk_q;
            end
            OP_PUSH: begin
                w_stk_we     = 1'b1;
                w_mark_we    = 1'b1;
                w_mark_wdata = 1'b1;
            end
            OP_FILL: begin
                w_stk_we     = 1'b1;
                w_stk_waddr  = IW'(r_sweep);
                w_stk_wdata  = IW'(r_sweep);
                w_mark_we    = 1'b1;
                w_mark_waddr = IW'(r_sweep);
                w_mark_wdata = CW'(r_sweep) < CW'(w_n);
            end
            default: ;
        endcase
    end

    // Free stack memory with registered read.
    always_ff @(posedge i_clk) begin
        if (w_stk_we) begin
            r_stack[w_stk_waddr] <= w_stk_wdata;
        end
        if (i_ctrl.op == OP_POP) begin
            r_stk_q <= r_stack[IW'(r_level - 9'd1)];
        end
    end

    // Free mark memory with registered read.
    always_ff @(posedge i_clk) begin
        if (w_mark_we) begin
            r_mark[w_mark_waddr] <= w_mark_wdata;
        end
        if (i_ctrl.op == OP_MARK_RD) begin
            r_mark_q <= r_mark[IW'(w_quot)];
        end
    end

    // Shared divider: block offset, then the percentages.
    always_comb begin
        w_div_start    = 1'b0;
        w_div_short    = 1'b1;
        w_div_dividend = 32'(w_pct_num);
        w_div_divisor  = 16'(w_n);
        case (i_ctrl.op)
            OP_DIV_OFF: begin
                w_div_start    = 1'b1;
                w_div_short    = 1'b0;
                w_div_dividend = r_off;
                w_div_divisor  = r_bb;
            end
            OP_DIV_FPCT, OP_DIV_UPCT: begin
                w_div_start = 1'b1;
            end
            default: ;
        endcase
    end

    fbpa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_short    (w_div_short),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_busy     (w_div_busy),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_out) begin
            r_out.status          <= r_status;
            r_out.granted_address <= r_grant;
            r_out.free_blocks     <= r_level;
            r_out.used_blocks     <= w_used;
            r_out.peak_used       <= r_peak;
            r_out.alloc_total     <= r_alloc;
            r_out.free_total      <= r_free;
            r_out.free_percent    <= r_fpct;
            r_out.usage_percent   <= r_upct;
        end
    end

    // Status to the controller.
    always_comb begin
        o_stat.cmd        = r_cmd;
        o_stat.level_zero = r_level == 9'd0;
        o_stat.range_ok   = r_range_ok;
        o_stat.rem_zero   = w_rem == 16'd0;
        o_stat.mark_set   = r_mark_q;
        o_stat.full       = w_full;
        o_stat.div_busy   = w_div_busy;
        o_stat.sweep_last = r_sweep == SW'(MAX_BLOCKS - 1);
    end

    assign o_out = r_out;

    // A pop never runs on an empty stack.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.op == OP_POP) |-> (r_level != 9'd0))
        else $error("pop issued on an empty free stack");

    // A push only happens with room left and the block not yet marked free.
    a_push_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.op == OP_PUSH) |-> (!w_full && !r_mark_q))
        else $error("push issued on a full stack or a block already free");

    // A pop lowers the level by exactly one.
    a_pop_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.op == OP_POP) |=> (r_level == $past(r_level) - 9'd1))
        else $error("stack level did not drop by one after a pop");

    // The divider is never restarted while it is still iterating.
    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_busy)
        else $error("divider started while busy");

endmodule

// ===== rtl/fbpa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Controller state machine: sequences one command at a time through the
// datapath and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module fbpa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  fbpa_pkg::t_dp_stat i_stat,
    output fbpa_pkg::t_ctrl    o_ctrl
);
    import fbpa_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    t_ctrl  w_ctrl;

    // State and output valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath operations.
    always_comb begin
        n_state           = r_state;
        n_out_valid       = r_out_valid && !i_out_ready;
        w_ctrl.op         = OP_NONE;
        w_ctrl.set_status = 1'b0;
        w_ctrl.status     = ST_OK;
        w_ctrl.load_out   = 1'b0;
        case (r_state)
            S_CLR: begin
                w_ctrl.op = OP_CLR_MARK;
                if (i_stat.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    w_ctrl.op = OP_CAPTURE;
                    n_state   = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.cmd)
                    CMD_ALLOC: begin
                        if (i_stat.level_zero) begin
                            w_ctrl.set_status = 1'b1;
                            w_ctrl.status     = ST_EMPTY;
                            n_state           = S_DIV_UPCT;
                        end else begin
                            n_state = S_POP;
                        end
                    end
                    CMD_FREE:   n_state = S_RANGE;
                    CMD_REINIT: n_state = S_REINIT;
                    default:    n_state = S_DIV_UPCT;
                endcase
            end
            S_POP: begin
                w_ctrl.op = OP_POP;
                n_state   = S_GMUL;
            end
            S_GMUL: begin
                w_ctrl.op = OP_GRANT_MUL;
                n_state   = S_GADD;
            end
            S_GADD: begin
                w_ctrl.op = OP_GRANT_ADD;
                n_state   = S_DIV_UPCT;
            end
            S_RANGE: begin
                w_ctrl.op = OP_RANGE;
                n_state   = S_DIV_OFF;
            end
            S_DIV_OFF: begin
                if (!i_stat.range_ok) begin
                    w_ctrl.set_status = 1'b1;
                    w_ctrl.status     = ST_BAD_ADDR;
                    n_state           = S_DIV_UPCT;
                end else begin
                    w_ctrl.op = OP_DIV_OFF;
                    n_state   = S_WAIT_OFF;
                end
            end
            S_WAIT_OFF: begin
                if (!i_stat.div_busy) begin
                    if (!i_stat.rem_zero) begin
                        w_ctrl.set_status = 1'b1;
                        w_ctrl.status     = ST_BAD_ADDR;
                        n_state           = S_DIV_UPCT;
                    end else begin
                        n_state = S_MARK_RD;
                    end
                end
            end
            S_MARK_RD: begin
                w_ctrl.op = OP_MARK_RD;
                n_state   = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.mark_set) begin
                    w_ctrl.set_status = 1'b1;
                    w_ctrl.status     = ST_ALREADY_FREE;
                    n_state           = S_DIV_UPCT;
                end else if (i_stat.full) begin
                    w_ctrl.set_status = 1'b1;
                    w_ctrl.status     = ST_FULL;
                    n_state           = S_DIV_UPCT;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                w_ctrl.op = OP_PUSH;
                n_state   = S_DIV_FPCT;
            end
            S_DIV_FPCT: begin
                w_ctrl.op = OP_DIV_FPCT;
                n_state   = S_WAIT_FPCT;
            end
            S_WAIT_FPCT: begin
                if (!i_stat.div_busy) begin
                    w_ctrl.op = OP_SET_FPCT;
                    n_state   = S_DIV_UPCT;
                end
            end
            S_REINIT: begin
                w_ctrl.op = OP_REINIT;
                n_state   = S_FILL;
            end
            S_FILL: begin
                w_ctrl.op = OP_FILL;
                if (i_stat.sweep_last) begin
                    n_state = S_DIV_UPCT;
                end
            end
            S_DIV_UPCT: begin
                w_ctrl.op = OP_DIV_UPCT;
                n_state   = S_WAIT_UPCT;
            end
            S_WAIT_UPCT: begin
                if (!i_stat.div_busy) begin
                    w_ctrl.op = OP_SET_UPCT;
                    n_state   = S_DONE;
                end
            end
            S_DONE: begin
                // Hand the result over once the output register is free.
                if (!r_out_valid || i_out_ready) begin
                    w_ctrl.load_out = 1'b1;
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ctrl      = w_ctrl;
    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

    // The result register is only reloaded when it is empty or being drained.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before its transfer");

    // A loaded result is offered in the next cycle.
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.load_out |=> r_out_valid)
        else $error("loaded result not offered");

    // No input is taken during the clearing pass after reset.
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !o_in_ready)
        else $error("input ready during mark clearing");

endmodule

// ===== rtl/fixed_block_pool_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_top
// Fixed-size block allocator with a LIFO free stack, free checking and
// usage statistics.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on the input channel (valid/ready) and each produces one
// result on the output channel (valid/ready). Configuration is a plain write
// port for pool base, block size and block count; the user writes it only
// while the block idles, which the block itself does not enforce. The pool
// must be reinitialized by command before first use. One command is worked
// on at a time. The shared radix-2 divider serves the alignment check of a
// free and each percentage. Reinitialize writes one stack entry per cycle.
// After reset the free marks are cleared, one entry a cycle, during which no
// command is taken; configuration writes still land.
// A finished result waits in the output register while the receiver stalls;
// the next command is accepted meanwhile and held at its end until the
// register has been drained.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_top #(
    parameter int MAX_BLOCKS = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  fbpa_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output fbpa_pkg::t_out  o_out,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [31:0]     i_cfg_data
);
    import fbpa_pkg::*;

    t_ctrl    w_ctrl;
    t_dp_stat w_stat;

    // Command sequencing and handshakes.
    fbpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_ctrl      (w_ctrl)
    );

    // Storage and arithmetic.
    fbpa_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_ctrl     (w_ctrl),
        .o_stat     (w_stat),
        .o_out      (o_out)
    );

endmodule
